### src/fir_filter_abs_assert.svh
// Assertion macros used by the filter controller RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef FIR_FILTER_ABS_ASSERT_SVH
`define FIR_FILTER_ABS_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ffa_pkg.sv
package ffa_pkg;

  localparam int COEF_BITS       = 18;
  localparam int COEF_FRAC       = 16;
  localparam int COEF_INDEX_BITS = 6;
  localparam int OUT_BITS        = 32;
  localparam int TAPS_BITS       = 7;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 7;

  localparam logic [TAPS_BITS-1:0] TAPS_RESET = 7'd64;

  // Request operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAPS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ABS  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic push;      // store sample, rewind read pointer, clear accumulator
    logic coef_wr;   // store one coefficient
    logic issue;     // read one tap pair into the MAC pipeline
    logic load_out;  // floor, saturate and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;      // MAC pipeline still holds products
  } ctrl_status_t;

endpackage

### src/fir_filter_abs.sv
// Direct-form FIR filter with saturation and optional magnitude output.
// Input channel (in_valid/in_stall): one request per accepted cycle. operation
// selects filtering of sample_in or storing coef_value at coef_index (Q2.16).
// Output channel (out_valid/out_stall): filtered and saturated, one result per
// sample request once the delay line holds taps_in_use samples; coefficient
// writes and samples taken while filling give no result.
// Configuration port (cfg_we/cfg_index/cfg_data): index 0 taps_in_use,
// index 1 absolute_mode; write only while the filter is idle.
// Sequence: a coefficient write leaves the filter idle. A sample that yields
// a result is summed by the single shared multiply-accumulate, one tap per
// cycle, then the pipeline drains and the output register is loaded; only
// after that load is the next request accepted.
// A stalled result stays in the output register; the next sample is accepted
// and summed meanwhile, and waits in its finish step until the slot is free.
// Reset clears the delay line fill count, the coefficient table (reads as
// zero), taps_in_use to 64 and absolute_mode to 0. No clearing sweep runs.
module fir_filter_abs #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     operation,
  input  logic signed [SAMPLE_BITS-1:0]            sample_in,
  input  logic [ffa_pkg::COEF_INDEX_BITS-1:0]      coef_index,
  input  logic signed [ffa_pkg::COEF_BITS-1:0]     coef_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ffa_pkg::OUT_BITS-1:0]      filtered,
  output logic                                     saturated,
  input  logic                                     cfg_we,
  input  logic [ffa_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [ffa_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import ffa_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);

  logic [TAPS_BITS-1:0] taps_in_use;
  logic                 absolute_mode;
  ctrl_cmd_t            cmd;
  ctrl_status_t         status;
  logic [AW-1:0]        tap;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use   <= TAPS_RESET;
      absolute_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAPS: taps_in_use   <= cfg_data[TAPS_BITS-1:0];
        CFG_ABS:  absolute_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accept requests, sweep the taps, hand off to the output slot
  ffa_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .taps_in_use (taps_in_use),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status),
    .tap         (tap)
  );

  // Storage, MAC pipeline, flooring and output register
  ffa_dp #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .tap           (tap),
    .absolute_mode (absolute_mode),
    .sample_in     (sample_in),
    .coef_index    (coef_index),
    .coef_value    (coef_value),
    .filtered      (filtered),
    .saturated     (saturated)
  );

endmodule

### src/ffa_ram.sv
module ffa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ffa_dp.sv
module ffa_dp #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ffa_pkg::ctrl_cmd_t                   cmd,
  output ffa_pkg::ctrl_status_t                status,
  input  logic [$clog2(MAX_TAPS)-1:0]          tap,
  input  logic                                 absolute_mode,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic [ffa_pkg::COEF_INDEX_BITS-1:0]  coef_index,
  input  logic signed [ffa_pkg::COEF_BITS-1:0] coef_value,
  output logic signed [ffa_pkg::OUT_BITS-1:0]  filtered,
  output logic                                 saturated
);
  import ffa_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int PW    = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W = PW + AW;
  localparam int QW    = ACC_W - COEF_FRAC;
  localparam int QXW   = (QW + 1 > OUT_BITS + 2) ? QW + 1 : OUT_BITS + 2;
  localparam int IXW   = ((AW > COEF_INDEX_BITS) ? AW : COEF_INDEX_BITS) + 1;
  localparam logic signed [QXW-1:0] SAT_HI =
    $signed({{(QXW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}});
  localparam logic signed [QXW-1:0] SAT_LO =
    $signed({{(QXW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}});

  logic [AW-1:0]                 wp;
  logic [AW-1:0]                 rp;
  logic [MAX_TAPS-1:0]           coef_vld;
  logic                          rd_cvld;
  logic                          s1_v;
  logic                          s2_v;
  logic signed [SAMPLE_BITS-1:0] rd_sample;
  logic signed [COEF_BITS-1:0]   rd_coef;
  logic signed [COEF_BITS-1:0]   coef_eff;
  logic signed [PW-1:0]          product;
  logic signed [ACC_W-1:0]       acc;
  logic [IXW-1:0]                cidx;
  logic                          coef_ok;
  logic signed [QW-1:0]          q;
  logic signed [QXW-1:0]         qx;
  logic signed [QXW-1:0]         mag;

  assign cidx    = IXW'(coef_index);
  assign coef_ok = cidx < IXW'(MAX_TAPS);

  ffa_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_delay (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (rp),
    .rdata (rd_sample)
  );

  ffa_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef (
    .clk   (clk),
    .we    (cmd.coef_wr && coef_ok),
    .waddr (cidx[AW-1:0]),
    .wdata (coef_value),
    .raddr (tap),
    .rdata (rd_coef)
  );

  // Circular delay line: wp is the next free slot, rp walks back from newest
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      coef_vld <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
    end else begin
      if (cmd.push) begin
        rp <= wp;
        wp <= (wp == AW'(MAX_TAPS - 1)) ? '0 : wp + 1'b1;
      end else if (cmd.issue) begin
        rp <= (rp == '0) ? AW'(MAX_TAPS - 1) : rp - 1'b1;
      end
      if (cmd.coef_wr && coef_ok) begin
        coef_vld[cidx[AW-1:0]] <= 1'b1;
      end
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
  end

  // Unwritten coefficients read as zero
  assign coef_eff = rd_cvld ? rd_coef : '0;

  always_ff @(posedge clk) begin
    rd_cvld <= coef_vld[tap];
    product <= coef_eff * rd_sample;
    if (cmd.push) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(product);
    end
  end

  assign status.busy = s1_v || s2_v;

  // Arithmetic shift floors, then optional magnitude, then clamp
  always_comb begin
    q   = $signed(acc[ACC_W-1:COEF_FRAC]);
    qx  = QXW'(q);
    mag = (absolute_mode && (qx < 0)) ? -qx : qx;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (mag > SAT_HI) begin
        filtered  <= SAT_HI[OUT_BITS-1:0];
        saturated <= 1'b1;
      end else if (mag < SAT_LO) begin
        filtered  <= SAT_LO[OUT_BITS-1:0];
        saturated <= 1'b1;
      end else begin
        filtered  <= mag[OUT_BITS-1:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule

### src/ffa_ctrl.sv
module ffa_ctrl #(
  parameter int MAX_TAPS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ffa_pkg::TAPS_BITS-1:0]  taps_in_use,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ffa_pkg::ctrl_cmd_t             cmd,
  input  ffa_pkg::ctrl_status_t          status,
  output logic [$clog2(MAX_TAPS)-1:0]    tap
);
  import ffa_pkg::*;

  `include "fir_filter_abs_assert.svh"

  localparam int AW = $clog2(MAX_TAPS);
  localparam int FW = $clog2(MAX_TAPS + 1);
  localparam int CW = (FW > TAPS_BITS) ? FW : TAPS_BITS;

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] tap_next;
  logic [FW-1:0] fill_count;
  logic [FW-1:0] fill_count_next;
  logic [FW-1:0] fill_inc;
  logic          out_valid_next;
  logic [CW-1:0] taps_x;
  logic [CW-1:0] eff;
  logic          accept;
  logic          want_result;

  // Clamp the tap count into 1..MAX_TAPS
  always_comb begin
    taps_x = CW'(taps_in_use);
    if (taps_x == '0) begin
      eff = CW'(1);
    end else if (taps_x > CW'(MAX_TAPS)) begin
      eff = CW'(MAX_TAPS);
    end else begin
      eff = taps_x;
    end
  end

  assign accept      = in_valid && !in_stall;
  assign fill_inc    = (fill_count < FW'(MAX_TAPS)) ? fill_count + 1'b1 : fill_count;
  assign want_result = CW'(fill_inc) >= eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tap        <= '0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      tap        <= tap_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    tap_next        = tap;
    fill_count_next = fill_count;
    out_valid_next  = out_valid && out_stall;
    cmd             = '0;
    in_stall        = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.push        = 1'b1;
            fill_count_next = fill_inc;
            if (want_result) begin
              state_next = ST_RUN;
              tap_next   = '0;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        tap_next  = tap + 1'b1;
        if (CW'(tap) == eff - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `FFA_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= FW'(MAX_TAPS), "fill count overran depth")
  `FFA_ASSERT_NEXT(a_sample_starts, accept && operation == OP_FILTER && want_result,
                   state == ST_RUN, "filled sample did not start the MAC sweep")
  `FFA_ASSERT_NEXT(a_tap_zero, state == ST_IDLE && state_next == ST_RUN, tap == '0,
                   "MAC sweep did not start at tap zero")
  `FFA_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE,
                  "result appeared outside the finish step")

endmodule
